@@ design/fpbq_pkg.sv @@
// Types, constants and saturating fixed-point helpers for the biquad shelving filter.
package fpbq_pkg;

	localparam int SAMPLE_W = 32;
	localparam int FIELD_W  = 32;
	localparam int FRAC_W   = SAMPLE_W - 1;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int EXT_W    = SAMPLE_W + 2;
	localparam int IDX_W    = 3;

	typedef logic signed [SAMPLE_W-1:0] smp_t;
	typedef logic signed [EXT_W-1:0]    ext_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [SAMPLE_W:0]   mq_t;

	typedef enum logic [IDX_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		smp_t b0;
		smp_t b1;
		smp_t b2;
		smp_t a1;
		smp_t a2;
	} coef_t;

	localparam ext_t EXT_MAX = {3'b000, {FRAC_W{1'b1}}};
	localparam ext_t EXT_MIN = {3'b111, {FRAC_W{1'b0}}};

	function automatic smp_t clamp(ext_t v);
		smp_t r;
		if (v > EXT_MAX) begin
			r = EXT_MAX[SAMPLE_W-1:0];
		end else if (v < EXT_MIN) begin
			r = EXT_MIN[SAMPLE_W-1:0];
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	// floor(a*b / 2^FRAC_W), clamped; only -1 * -1 overflows
	function automatic smp_t frac_mul(smp_t a, smp_t b);
		prod_t p;
		mq_t   q;
		p = PROD_W'(a) * PROD_W'(b);
		q = p[PROD_W-1:FRAC_W];
		return clamp(EXT_W'(q));
	endfunction

	function automatic smp_t sat_add(smp_t a, smp_t b);
		return clamp(EXT_W'(a) + EXT_W'(b));
	endfunction

	function automatic smp_t sat_sub(smp_t a, smp_t b);
		return clamp(EXT_W'(a) - EXT_W'(b));
	endfunction

	function automatic smp_t sat_shl2(smp_t a);
		return clamp(EXT_W'(a) <<< 2);
	endfunction

endpackage

@@ design/fpbq_coef_regs.sv @@
// Coefficient register bank written through the configuration channel.
module fpbq_coef_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [fpbq_pkg::IDX_W-1:0]   wr_index,
	input  logic [fpbq_pkg::FIELD_W-1:0] wr_data,
	output fpbq_pkg::coef_t              coef
);
	import fpbq_pkg::*;

	coef_t coef_q;
	smp_t  wr_val;

	assign wr_val = wr_data[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_B0: coef_q.b0 <= wr_val;
				REG_B1: coef_q.b1 <= wr_val;
				REG_B2: coef_q.b2 <= wr_val;
				REG_A1: coef_q.a1 <= wr_val;
				REG_A2: coef_q.a2 <= wr_val;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

@@ design/fpbq_datapath.sv @@
// Direct form I biquad arithmetic with input and output history registers.
module fpbq_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  fpbq_pkg::coef_t      coef,
	input  fpbq_pkg::smp_t       x0,
	input  logic                 clr_hist,
	output fpbq_pkg::smp_t       y
);
	import fpbq_pkg::*;

	smp_t x1_q, x2_q, y1_q, y2_q;
	smp_t x1, x2, y1, y2;
	smp_t ff1, ff, fb, acc;

	assign x1 = clr_hist ? '0 : x1_q;
	assign x2 = clr_hist ? '0 : x2_q;
	assign y1 = clr_hist ? '0 : y1_q;
	assign y2 = clr_hist ? '0 : y2_q;

	always_comb begin
		ff1 = sat_add(frac_mul(coef.b0, x0), frac_mul(coef.b1, x1));
		ff  = sat_add(ff1, frac_mul(coef.b2, x2));
		fb  = sat_add(frac_mul(coef.a1, y1), frac_mul(coef.a2, y2));
		acc = sat_sub(ff, fb);
		y   = sat_shl2(acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (adv) begin
			x1_q <= x0;
			x2_q <= x1;
			y1_q <= y;
			y2_q <= y1;
		end
	end

endmodule

@@ design/fixed_point_biquad_shelving_filter_core.sv @@
// Top level of the fixed-point biquad shelving filter: handshakes, stage registers.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | sample_in, frame_start
//  out     | output    | out_valid / out_stall | sample_out
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Result is registered in y_q after the input register x_s1; one item per cycle sustained while out_stall is low.
// The cycle time is set by the five parallel 32x32 products feeding the saturating adds,
// a path that also closes the output feedback loop.
// Reset clears coefficients, histories and valid flags; no clearing pass.
// A stalled output holds one result while one more item waits in the input register.
module fixed_point_biquad_shelving_filter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [fpbq_pkg::FIELD_W-1:0] sample_in,
	input  logic                         frame_start,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fpbq_pkg::FIELD_W-1:0] sample_out,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fpbq_pkg::IDX_W-1:0]   cfg_index,
	input  logic [fpbq_pkg::FIELD_W-1:0] cfg_data
);
	import fpbq_pkg::*;

	coef_t coef;
	logic  valid_s1;
	smp_t  x_s1;
	logic  fs_s1;
	logic  out_valid_q;
	smp_t  y_q;
	smp_t  y;
	logic  out_free;
	logic  adv;
	logic  load;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign load      = in_valid && !in_stall;

	fpbq_coef_regs u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	fpbq_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.coef     (coef),
		.x0       (x_s1),
		.clr_hist (fs_s1),
		.y        (y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_s1  <= sample_in[SAMPLE_W-1:0];
			fs_s1 <= frame_start;
		end
		if (adv) begin
			y_q <= y;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = FIELD_W'(y_q);

`ifndef SYNTHESIS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=> (valid_s1 && $stable(x_s1)))
		else $error("input stage lost an item while output stalled");

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced item did not reach output register");

	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv))
		else $error("result appeared without an item advancing");
`endif

endmodule
